FILE: rtl/mcb_pkg.sv
// ----------------------------------------------------------------------------
// mcb_pkg
// shared types and constants of the masked coverage binner
// ----------------------------------------------------------------------------
package mcb_pkg;

   localparam int MAX_BINS_DEF   = 64;
   localparam int HALF_WIN_DEF   = 50;
   localparam int POS_W          = 28;
   localparam int COV_W          = 16;
   localparam int BSIZE_W        = 20;
   localparam int SUM_W          = 40;
   localparam int CNT_W          = 21;
   localparam int FIRST_W        = 29;
   localparam int VAL_W          = 24;
   localparam int KEPT_W         = 32;
   localparam int MEAN_W         = 32;   // mean capped at 2^31
   localparam int TOTAL_W        = 40;   // 256 means of 2^31
   localparam int CSR_W          = 20;
   localparam int BSIZE_RESET    = 1000;

   localparam logic CSR_STRAND  = 1'b0;
   localparam logic CSR_BINSIZE = 1'b1;

   // commands from controller to datapath
   typedef struct packed {
      logic push;       // take request into lookahead line
      logic retire;     // retire oldest line entry
      logic clr;        // clear region state (sweep)
      logic mean_go;    // start mean division for bin
      logic norm_go;    // start normalize division for bin
      logic out_load;   // load output register
   } ctl_type;

   // status from datapath to controller
   typedef struct packed {
      logic line_full;
      logic line_empty;
      logic div_busy;
   } sts_type;

endpackage

FILE: rtl/mcb_div.sv
// ----------------------------------------------------------------------------
// mcb_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mcb_div
   import mcb_pkg::*;
#(
   parameter int NUM_W = 64,
   parameter int DEN_W = 40
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic [NUM_W-1:0] quot
);
   localparam int CW = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W:0]   r_ff, r_in;
   logic [DEN_W-1:0] d_ff, d_in;
   logic [CW-1:0]    n_ff, n_in;
   logic [DEN_W:0]   sh;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      n_in = n_ff;
      sh   = {r_ff[DEN_W-1:0], q_ff[NUM_W-1]};
      if (start) begin
         q_in = num;
         r_in = '0;
         d_in = den;
         n_in = CW'(NUM_W);
      end else if (n_ff != '0) begin
         if (sh >= {1'b0, d_ff}) begin
            r_in = sh - {1'b0, d_ff};
            q_in = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            r_in = sh;
            q_in = {q_ff[NUM_W-2:0], 1'b0};
         end
         n_in = n_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      if (reset) n_ff <= '0;
      else       n_ff <= n_in;
   end

   assign busy = (n_ff != '0);
   assign quot = q_ff;
endmodule

FILE: rtl/mcb_datapath.sv
// ----------------------------------------------------------------------------
// mcb_datapath
// lookahead line, masking, bin stores and normalization arithmetic
// ----------------------------------------------------------------------------
module mcb_datapath
   import mcb_pkg::*;
#(
   parameter int MAX_BINS = MAX_BINS_DEF,
   parameter int HALF_WIN = HALF_WIN_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ctl_type                 ctl,
   input  logic [$clog2(MAX_BINS)-1:0] bin_idx,
   output sts_type                 sts,
   output logic [$clog2(MAX_BINS+1)-1:0] nb,
   input  logic                    strand_minus,
   input  logic [BSIZE_W-1:0]      bin_size,
   input  logic [POS_W-1:0]        in_pos,
   input  logic signed [COV_W-1:0] in_cov,
   input  logic                    in_map,
   output logic [VAL_W-1:0]        out_val,
   output logic signed [FIRST_W-1:0] out_first
);
   localparam int BW = $clog2(MAX_BINS);
   localparam int LW = $clog2(HALF_WIN + 1);
   localparam int HW = (HALF_WIN > 1) ? $clog2(HALF_WIN) : 1;
   localparam int NBW = $clog2(MAX_BINS + 1);
   localparam int DN = SUM_W + 16;

   // lookahead line: shift register, entry 0 oldest
   logic [POS_W-1:0]        lp_ff [HALF_WIN];
   logic signed [COV_W-1:0] lc_ff [HALF_WIN];
   logic [HALF_WIN-1:0]     lm_ff;   // mappable
   logic [HALF_WIN-1:0]     lv_ff;   // valid
   logic [LW-1:0]           fill_ff;

   logic              unm_ff;
   logic [POS_W-1:0]  unp_ff;
   logic [KEPT_W-1:0] kept_ff;
   logic [BSIZE_W-1:0] in_bin_ff;   // position within current bin
   logic [BW-1:0]     cur_ff;       // current bin

   // running totals of the current bin, written through to the bin store
   logic [SUM_W-1:0]          asum_ff;
   logic [CNT_W-1:0]          acnt_ff;
   logic signed [FIRST_W-1:0] afirst_ff;

   logic [SUM_W-1:0]  bsum_ff  [MAX_BINS];
   logic [CNT_W-1:0]  bcnt_ff  [MAX_BINS];
   logic signed [FIRST_W-1:0] bfirst_ff [MAX_BINS];
   logic [MEAN_W-1:0] mean_ff  [MAX_BINS];
   logic [TOTAL_W-1:0] total_ff;
   logic [NBW-1:0]    nb_ff;

   // registered reads of the bin stores at bin_idx
   logic [SUM_W-1:0]          rsum_ff;
   logic [CNT_W-1:0]          rcnt_ff;
   logic signed [FIRST_W-1:0] rfirst_ff;
   logic [MEAN_W-1:0]         rmean_ff;

   function automatic logic near_f(input logic [POS_W-1:0] u, input logic [POS_W-1:0] p);
      logic signed [POS_W+1:0] d;
      d = $signed({2'b0, p}) - $signed({2'b0, u});
      return (d >= -(POS_W+2)'(HALF_WIN)) && (d <= (POS_W+2)'(HALF_WIN - 1));
   endfunction

   // retire decision for entry 0
   logic masked, wrong, keep;
   logic [COV_W:0] mag;
   logic [BSIZE_W-1:0] bs_eff;
   always_comb begin
      masked = !lm_ff[0];
      if (unm_ff && near_f(unp_ff, lp_ff[0])) masked = 1'b1;
      for (int j = 1; j < HALF_WIN; j++)
         if (lv_ff[j] && !lm_ff[j] && near_f(lp_ff[j], lp_ff[0])) masked = 1'b1;
      // the item entering the line this cycle is the youngest neighbor
      if (ctl.push && !in_map && near_f(in_pos, lp_ff[0])) masked = 1'b1;
      wrong = strand_minus ? (lc_ff[0] > 0) : (lc_ff[0] < 0);
      keep  = !masked && !wrong;
      mag   = strand_minus ? (COV_W+1)'(-$signed({lc_ff[0][COV_W-1], lc_ff[0]}))
                           : (COV_W+1)'($signed({lc_ff[0][COV_W-1], lc_ff[0]}));
      bs_eff = (bin_size == '0) ? BSIZE_W'(1) : bin_size;
   end

   // divider shared between mean and normalize passes
   logic          dv_start, dv_busy;
   logic [DN-1:0] dv_num, dv_quot;
   logic [TOTAL_W-1:0] dv_den;
   logic          norm_ff, rd_ff;
   logic          mgo_ff, ngo_ff, olo_ff;
   logic [BW-1:0] didx_ff;

   // starts are registered so that they line up with the registered store reads
   always_comb begin
      dv_start = mgo_ff || ngo_ff;
      if (ngo_ff) begin
         dv_num = DN'({(MEAN_W+NBW)'(rmean_ff) * (MEAN_W+NBW)'(nb_ff), 16'b0});
         dv_den = total_ff;
      end else begin
         dv_num = {rsum_ff, 16'b0};
         dv_den = TOTAL_W'(rcnt_ff);
      end
   end

   mcb_div #(.NUM_W(DN), .DEN_W(TOTAL_W)) u_div (
      .clock(clock), .reset(reset), .start(dv_start), .num(dv_num), .den(dv_den),
      .busy(dv_busy), .quot(dv_quot)
   );

   logic [MEAN_W-1:0] mcap;
   logic [VAL_W-1:0]  vcap;
   always_comb begin
      mcap = (dv_quot > DN'(64'h8000_0000)) ? MEAN_W'(32'h8000_0000) : MEAN_W'(dv_quot);
      vcap = (dv_quot > DN'({VAL_W{1'b1}})) ? {VAL_W{1'b1}} : VAL_W'(dv_quot);
   end

   logic [SUM_W:0] sum_add;
   logic [SUM_W-1:0] nsum;
   logic [CNT_W-1:0] ncnt;
   logic signed [FIRST_W-1:0] nfirst;
   logic bin_done;
   always_comb begin
      sum_add  = {1'b0, asum_ff} + (SUM_W+1)'(mag);
      nsum     = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
      ncnt     = (acnt_ff == {CNT_W{1'b1}}) ? acnt_ff : acnt_ff + 1'b1;
      nfirst   = (afirst_ff == -1) ? $signed({1'b0, lp_ff[0]}) : afirst_ff;
      bin_done = (kept_ff != {KEPT_W{1'b1}}) && (in_bin_ff + 1'b1 >= bs_eff)
                 && (cur_ff != BW'(MAX_BINS - 1));
   end

   always_ff @(posedge clock) begin
      rsum_ff   <= bsum_ff[bin_idx];
      rcnt_ff   <= bcnt_ff[bin_idx];
      rfirst_ff <= bfirst_ff[bin_idx];
      rmean_ff  <= mean_ff[bin_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lv_ff    <= '0;
         fill_ff  <= '0;
         rd_ff    <= 1'b0;
         mgo_ff   <= 1'b0;
         ngo_ff   <= 1'b0;
         olo_ff   <= 1'b0;
      end else begin
         // line shift / push
         if (ctl.retire) begin
            for (int j = 0; j < HALF_WIN - 1; j++) begin
               lp_ff[j] <= lp_ff[j+1];
               lc_ff[j] <= lc_ff[j+1];
               lm_ff[j] <= lm_ff[j+1];
               lv_ff[j] <= lv_ff[j+1];
            end
            lv_ff[HALF_WIN-1] <= 1'b0;
            if (ctl.push) begin
               lp_ff[HW'(fill_ff - 1'b1)] <= in_pos;
               lc_ff[HW'(fill_ff - 1'b1)] <= in_cov;
               lm_ff[HW'(fill_ff - 1'b1)] <= in_map;
               lv_ff[HW'(fill_ff - 1'b1)] <= 1'b1;
            end else begin
               fill_ff <= fill_ff - 1'b1;
            end
         end else if (ctl.push) begin
            lp_ff[HW'(fill_ff)] <= in_pos;
            lc_ff[HW'(fill_ff)] <= in_cov;
            lm_ff[HW'(fill_ff)] <= in_map;
            lv_ff[HW'(fill_ff)] <= 1'b1;
            fill_ff <= fill_ff + 1'b1;
         end
         mgo_ff <= ctl.mean_go;
         ngo_ff <= ctl.norm_go;
         olo_ff <= ctl.out_load;
         // result pending from start until the divider is done
         if (dv_start) rd_ff <= 1'b1;
         else if (!dv_busy) rd_ff <= 1'b0;
         if (dv_start) begin
            norm_ff <= ngo_ff;
            didx_ff <= bin_idx;
         end
      end
      // retire into bins
      if (ctl.retire) begin
         if (!lm_ff[0]) begin
            unm_ff <= 1'b1;
            unp_ff <= lp_ff[0];
         end
         if (keep) begin
            bsum_ff[cur_ff]   <= nsum;
            bcnt_ff[cur_ff]   <= ncnt;
            bfirst_ff[cur_ff] <= nfirst;
            if (bin_done) begin
               asum_ff <= '0; acnt_ff <= '0; afirst_ff <= '1;
            end else begin
               asum_ff <= nsum; acnt_ff <= ncnt; afirst_ff <= nfirst;
            end
            if (kept_ff != {KEPT_W{1'b1}}) begin
               kept_ff <= kept_ff + 1'b1;
               if (nb_ff == '0) nb_ff <= NBW'(1);
               if (in_bin_ff + 1'b1 >= bs_eff) begin
                  in_bin_ff <= '0;
                  if (cur_ff != BW'(MAX_BINS - 1)) cur_ff <= cur_ff + 1'b1;
               end else begin
                  in_bin_ff <= in_bin_ff + 1'b1;
               end
               if (in_bin_ff == '0 && kept_ff != '0 && nb_ff != NBW'(MAX_BINS))
                  nb_ff <= nb_ff + 1'b1;
            end
         end
      end
      // division results: once the divider is done
      if (!dv_busy && !dv_start && rd_ff) begin
         if (!norm_ff) begin
            mean_ff[didx_ff] <= (rcnt_ff == '0) ? '0 : mcap;
            total_ff <= total_ff + TOTAL_W'((rcnt_ff == '0) ? '0 : mcap);
         end else begin
            out_val <= (total_ff == '0) ? '0 : vcap;
         end
      end
      if (olo_ff) out_first <= rfirst_ff;
      if (ctl.clr) begin
         if (bin_idx == '0) begin
            unm_ff <= 1'b0; kept_ff <= '0; in_bin_ff <= '0; cur_ff <= '0;
            nb_ff <= '0; total_ff <= '0;
            asum_ff <= '0; acnt_ff <= '0; afirst_ff <= '1;
         end
      end
   end

   assign sts.line_full  = (fill_ff == LW'(HALF_WIN));
   assign sts.line_empty = (fill_ff == '0);
   assign sts.div_busy   = dv_busy || dv_start || rd_ff;
   assign nb = nb_ff;
endmodule

FILE: rtl/mcb_ctrl.sv
// ----------------------------------------------------------------------------
// mcb_ctrl
// controller: streaming, drain, mean pass, normalize pass, emit, clear
// ----------------------------------------------------------------------------
module mcb_ctrl
   import mcb_pkg::*;
#(
   parameter int MAX_BINS = MAX_BINS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_last,
   input  sts_type     sts,
   input  logic [$clog2(MAX_BINS+1)-1:0] nb,
   output ctl_type     ctl,
   output logic [$clog2(MAX_BINS)-1:0] bin_idx
);
   localparam int BW = $clog2(MAX_BINS);

   typedef enum logic [2:0] {
      S_CLEAR, S_RUN, S_DRAIN, S_MEAN, S_NORM, S_OUT, S_WAIT
   } state_type;

   state_type state_ff;
   logic [BW-1:0] idx_ff;
   logic          go_ff, vld_ff, last_ff;
   logic          acc;

   assign req_stall = (state_ff != S_RUN);
   assign acc = req_valid && !req_stall;

   always_comb begin
      ctl = '0;
      ctl.push   = acc;
      ctl.retire = (acc && sts.line_full) || (state_ff == S_DRAIN && !sts.line_empty);
      ctl.clr    = (state_ff == S_CLEAR);
      ctl.mean_go = (state_ff == S_MEAN) && go_ff;
      ctl.norm_go = (state_ff == S_NORM) && go_ff;
      ctl.out_load = (state_ff == S_NORM) && go_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         idx_ff   <= '0;
         go_ff    <= 1'b0;
         vld_ff   <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         go_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == BW'(MAX_BINS - 1)) state_ff <= S_RUN;
            end
            S_RUN: if (acc && req_last) state_ff <= S_DRAIN;
            S_DRAIN: if (sts.line_empty) begin
               idx_ff <= '0;
               if (nb == '0) state_ff <= S_CLEAR;
               else begin state_ff <= S_MEAN; go_ff <= 1'b1; end
            end
            S_MEAN: if (!go_ff && !sts.div_busy) begin
               if ({1'b0, idx_ff} + 1'b1 == nb) begin
                  idx_ff <= '0; state_ff <= S_NORM;
               end else idx_ff <= idx_ff + 1'b1;
               go_ff <= 1'b1;
            end
            S_NORM: if (!go_ff && !sts.div_busy) begin
               vld_ff  <= 1'b1;
               last_ff <= ({1'b0, idx_ff} + 1'b1 == nb);
               state_ff <= S_OUT;
            end
            S_OUT: if (!rsp_stall) begin
               vld_ff <= 1'b0;
               if (last_ff) begin idx_ff <= '0; state_ff <= S_CLEAR; end
               else begin idx_ff <= idx_ff + 1'b1; state_ff <= S_NORM; go_ff <= 1'b1; end
            end
            default: state_ff <= S_CLEAR;
         endcase
      end
   end

   assign bin_idx   = idx_ff;
   assign rsp_valid = vld_ff;
   assign rsp_last  = last_ff;
endmodule

FILE: rtl/masked_coverage_binner_top.sv
// ----------------------------------------------------------------------------
// masked_coverage_binner_top
// bins masked coverage of one region and emits normalized bin levels
// ----------------------------------------------------------------------------
// channel | ports                                          | direction
// req     | req_valid req_stall req_position req_coverage  | in
//         | req_mappable req_last_item                     |
// rsp     | rsp_valid rsp_stall rsp_bin_value              | out
//         | rsp_first_position rsp_last_bin                |
// csr     | csr_write csr_index csr_data                   | in
//
// one item per cycle while streaming; the last item drains the lookahead
// line, then two passes of the shared 56-bit serial divider, one division
// per bin each, set the result rate
// after reset and after each region a clearing pass over all MAX_BINS bin
// indices runs with req_stall high; csr writes are taken at any time
// rsp_stall holds the result register and the whole walk
module masked_coverage_binner_top
   import mcb_pkg::*;
#(
   parameter int MAX_BINS = MAX_BINS_DEF,
   parameter int MASK_HALF_WINDOW = HALF_WIN_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [POS_W-1:0]          req_position,
   input  logic signed [COV_W-1:0]   req_coverage,
   input  logic                      req_mappable,
   input  logic                      req_last_item,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [VAL_W-1:0]          rsp_bin_value,
   output logic signed [FIRST_W-1:0] rsp_first_position,
   output logic                      rsp_last_bin,
   input  logic                      csr_write,
   input  logic                      csr_index,
   input  logic [CSR_W-1:0]          csr_data
);
   ctl_type ctl;
   sts_type sts;
   logic [$clog2(MAX_BINS)-1:0]   bin_idx;
   logic [$clog2(MAX_BINS+1)-1:0] nb;
   logic               strand_ff;
   logic [BSIZE_W-1:0] bsize_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         strand_ff <= 1'b0;
         bsize_ff  <= BSIZE_W'(BSIZE_RESET);
      end else if (csr_write) begin
         case (csr_index)
            CSR_STRAND:  strand_ff <= csr_data[0];
            CSR_BINSIZE: bsize_ff  <= csr_data[BSIZE_W-1:0];
            default: ;
         endcase
      end
   end

   mcb_ctrl #(.MAX_BINS(MAX_BINS)) u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_last(req_last_item), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_last(rsp_last_bin), .sts(sts), .nb(nb), .ctl(ctl), .bin_idx(bin_idx)
   );

   mcb_datapath #(.MAX_BINS(MAX_BINS), .HALF_WIN(MASK_HALF_WINDOW)) u_dp (
      .clock(clock), .reset(reset), .ctl(ctl), .bin_idx(bin_idx), .sts(sts), .nb(nb),
      .strand_minus(strand_ff), .bin_size(bsize_ff), .in_pos(req_position),
      .in_cov(req_coverage), .in_map(req_mappable), .out_val(rsp_bin_value),
      .out_first(rsp_first_position)
   );
endmodule

FILE: rtl/mcb_checker.sv
// ----------------------------------------------------------------------------
// mcb_assertions
// port-level checks of the masked coverage binner
// ----------------------------------------------------------------------------
module mcb_assertions
   import mcb_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic req_last_item,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_last_bin,
   input logic [VAL_W-1:0] rsp_bin_value
);
   // no input taken while results are pending
   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("input taken during emit");

   // a last item closes the input side next cycle
   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_last_item) |=> req_stall)
      else $error("input open after last item");

   // result holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_bin_value) && $stable(rsp_last_bin)))
      else $error("result changed under stall");
endmodule

bind masked_coverage_binner_top mcb_assertions u_mcb_assertions (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .req_last_item(req_last_item), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_last_bin(rsp_last_bin), .rsp_bin_value(rsp_bin_value)
);

FILE: verif/mcb_checker.sv
// ----------------------------------------------------------------------------
// mcb_checker
// watches the req, rsp and csr ports of the masked coverage binner, predicts
// the bins of each region and compares every accepted bin field by field
// ----------------------------------------------------------------------------
module mcb_checker
   import mcb_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic [POS_W-1:0]          req_position,
   input  logic signed [COV_W-1:0]   req_coverage,
   input  logic                      req_mappable,
   input  logic                      req_last_item,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic [VAL_W-1:0]          rsp_bin_value,
   input  logic signed [FIRST_W-1:0] rsp_first_position,
   input  logic                      rsp_last_bin,
   input  logic                      csr_write,
   input  logic                      csr_index,
   input  logic [CSR_W-1:0]          csr_data,
   output int                        fail_count,
   output int                        pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MB = MAX_BINS_DEF;
   localparam int HW = HALF_WIN_DEF;
   localparam longint unsigned SUM_MAX  = (64'd1 << SUM_W) - 1;
   localparam longint unsigned CNT_MAX  = (64'd1 << CNT_W) - 1;
   localparam longint unsigned MEAN_MAX = 64'd1 << 31;
   localparam longint unsigned VAL_MAX  = (64'd1 << VAL_W) - 1;

   typedef struct {
      logic [POS_W-1:0]        pos;
      logic signed [COV_W-1:0] cov;
      logic                    map;
   } base_t;

   typedef struct {
      logic [VAL_W-1:0]          level;
      logic signed [FIRST_W-1:0] first;
      logic                      last;
   } bin_t;

   base_t                     line_q[$];
   bit                        unm_seen;
   logic [POS_W-1:0]          last_unm;
   logic [KEPT_W-1:0]         kept;
   logic [SUM_W-1:0]          bsum[MB];
   logic [CNT_W-1:0]          bcnt[MB];
   logic signed [FIRST_W-1:0] bfirst[MB];
   bit                        strand_minus;
   logic [BSIZE_W-1:0]        bin_size;
   bin_t                      bins_q[$];
   int                        fails;

   function automatic bit near_unm(logic [POS_W-1:0] u, logic [POS_W-1:0] p);
      longint uu;
      longint pp;
      uu = u;
      pp = p;
      return pp >= uu - HW && pp <= uu + HW - 1;
   endfunction

   function void clear_region();
      line_q.delete();
      unm_seen = 0;
      last_unm = '0;
      kept = '0;
      for (int i = 0; i < MB; i++) begin
         bsum[i] = '0;
         bcnt[i] = '0;
         bfirst[i] = '1;
      end
   endfunction

   function void retire_base(base_t e);
      bit masked;
      logic [31:0] mag;
      logic [31:0] bs;
      logic [31:0] b;
      longint unsigned t;
      masked = !e.map;
      if (unm_seen && near_unm(last_unm, e.pos)) masked = 1;
      foreach (line_q[j])
         if (!line_q[j].map && near_unm(line_q[j].pos, e.pos)) masked = 1;
      if (!e.map) begin
         unm_seen = 1;
         last_unm = e.pos;
      end
      if (masked) return;
      if (strand_minus) begin
         if (e.cov > 0) return;
         mag = -int'(e.cov);
      end else begin
         if (e.cov < 0) return;
         mag = int'(e.cov);
      end
      bs = (bin_size == 0) ? 1 : bin_size;
      b = kept / bs;
      if (b >= MB) b = MB - 1;
      t = longint'(bsum[b]) + mag;
      bsum[b] = (t > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : t[SUM_W-1:0];
      if (bcnt[b] < CNT_MAX) bcnt[b] = bcnt[b] + 1'b1;
      if (bfirst[b] == -1) bfirst[b] = {1'b0, e.pos};
      if (kept != '1) kept = kept + 1'b1;
   endfunction

   // one base in; on the last base the line drains and the bins are queued
   function void take_base(base_t s, bit last);
      base_t old;
      longint unsigned mean[MB];
      longint unsigned total;
      longint unsigned v;
      int nb;
      logic [31:0] bs;
      bin_t r;
      if (line_q.size() == HW) begin
         old = line_q.pop_front();
         line_q.push_back(s);
         retire_base(old);
      end else begin
         line_q.push_back(s);
      end
      if (!last) return;
      while (line_q.size() > 0) begin
         old = line_q.pop_front();
         retire_base(old);
      end
      bs = (bin_size == 0) ? 1 : bin_size;
      nb = (kept == 0) ? 0 : int'((kept - 1) / bs) + 1;
      if (nb > MB) nb = MB;
      total = 0;
      for (int i = 0; i < nb; i++) begin
         mean[i] = 0;
         if (bcnt[i] > 0) begin
            mean[i] = (longint'(bsum[i]) << 16) / bcnt[i];
            if (mean[i] > MEAN_MAX) mean[i] = MEAN_MAX;
         end
         total += mean[i];
      end
      for (int i = 0; i < nb; i++) begin
         v = 0;
         if (total > 0) begin
            v = ((mean[i] * nb) << 16) / total;
            if (v > VAL_MAX) v = VAL_MAX;
         end
         r.level = v[VAL_W-1:0];
         r.first = bfirst[i];
         r.last = (i + 1 == nb);
         bins_q.push_back(r);
      end
      clear_region();
   endfunction

   always @(posedge clock) begin
      base_t s;
      bin_t e;
      if (reset) begin
         strand_minus = 0;
         bin_size = BSIZE_W'(BSIZE_RESET);
         clear_region();
         bins_q.delete();
         fails = 0;
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_STRAND) strand_minus = csr_data[0];
            else bin_size = csr_data[BSIZE_W-1:0];
         end
         if (req_valid && !req_stall) begin
            s.pos = req_position;
            s.cov = req_coverage;
            s.map = req_mappable;
            take_base(s, req_last_item);
         end
         if (rsp_valid && !rsp_stall) begin
            if (bins_q.size() == 0) begin
               $display("%0t unexpected bin: bin_value %0d first_position %0d last_bin %0d",
                        $time, rsp_bin_value, rsp_first_position, rsp_last_bin);
               fails++;
            end else begin
               e = bins_q.pop_front();
               if (rsp_bin_value !== e.level) begin
                  $display("%0t bin_value expected %0d actual %0d",
                           $time, e.level, rsp_bin_value);
                  fails++;
               end
               if (rsp_first_position !== e.first) begin
                  $display("%0t first_position expected %0d actual %0d",
                           $time, e.first, rsp_first_position);
                  fails++;
               end
               if (rsp_last_bin !== e.last) begin
                  $display("%0t last_bin expected %0d actual %0d",
                           $time, e.last, rsp_last_bin);
                  fails++;
               end
            end
         end
      end
      fail_count <= fails;
      pending <= bins_q.size();
   end

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// drives regions of per-base samples and csr settings into the masked
// coverage binner with random gaps and stalls; the checker judges the bins
// ----------------------------------------------------------------------------
module tb;
   import mcb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG = 40000;   // idle cycles, far above drain plus two divider walks
   localparam int SETTLE   = 300;     // drain, divider and clearing pass after a region
   localparam int N_ITEMS  = 360;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [POS_W-1:0]          req_position = '0;
   logic signed [COV_W-1:0]   req_coverage = '0;
   logic                      req_mappable = 1'b1;
   logic                      req_last_item = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [VAL_W-1:0]          rsp_bin_value;
   logic signed [FIRST_W-1:0] rsp_first_position;
   logic                      rsp_last_bin;
   logic                      csr_write = 1'b0;
   logic                      csr_index = CSR_STRAND;
   logic [CSR_W-1:0]          csr_data = '0;

   int  fail_count;
   int  pending;
   int  items_sent = 0;
   int  regions = 0;
   int  bins_seen = 0;
   int  idle_cycles = 0;
   int  stall_left = 0;
   bit  req_busy = 0;    // sender draws gaps when set
   bit  rsp_busy = 0;    // receiver draws stalls when set
   bit  strand_now = 0;
   logic [BSIZE_W-1:0] bsize_now = BSIZE_W'(BSIZE_RESET);

   masked_coverage_binner_top DUT (.*);

   mcb_checker u_checker (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver: random stalls per bin, with calm stretches where it never stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if ($urandom_range(0, 199) == 0) rsp_busy = !rsp_busy;
         if (rsp_valid && !rsp_stall) bins_seen++;
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (rsp_valid && !rsp_stall && rsp_busy) stall_left = $urandom_range(0, 14);
         end
      end
   end

   // watchdog on cycles where nothing moves
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write || reset)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // one item; valid stays high into the next item when no gap is drawn
   task automatic send_base(logic [POS_W-1:0] pos, logic signed [COV_W-1:0] cov,
                            logic map, logic last);
      int gap;
      gap = req_busy ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_position <= pos;
      req_coverage <= cov;
      req_mappable <= map;
      req_last_item <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // sender holds off until every expected bin is in and the block has settled
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [CSR_W-1:0] value);
      wait_idle();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_STRAND) strand_now = value[0];
      else bsize_now = value[BSIZE_W-1:0];
   endtask

   // coverage for the current strand, sometimes wrong sign, extreme or raw bits
   function automatic logic signed [COV_W-1:0] pick_cov();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return COV_W'($urandom);
      if (r < 12) return strand_now ? -16'sd32768 : 16'sd32767;
      if (r < 16) return 16'sd0;
      if (r < 24) return strand_now ? COV_W'($urandom_range(1, 32767))
                                    : COV_W'(-$urandom_range(1, 32768));
      return strand_now ? COV_W'(-$urandom_range(0, 32768)) : COV_W'($urandom_range(0, 32767));
   endfunction

   // one region walking in strand order; unm_pm is the per-mille unmappable rate
   task automatic send_region(int len, int unm_pm, bit scramble);
      logic [POS_W-1:0] pos;
      pos = POS_W'($urandom);
      for (int i = 0; i < len; i++) begin
         send_base(pos, pick_cov(), ($urandom_range(0, 999) >= unm_pm),
                   (i == len - 1));
         if (scramble) pos = POS_W'($urandom);
         else if (strand_now) pos = pos - 1'b1;
         else pos = pos + 1'b1;
      end
      regions++;
   endtask

   initial begin
      int len;
      int r;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // zero coverage everywhere: mean over bins is zero
      send_base(28'd10, 16'sd0, 1'b1, 1'b0);
      send_base(28'd11, 16'sd0, 1'b1, 1'b0);
      send_base(28'd12, 16'sd0, 1'b1, 1'b1);
      regions++;

      // top coordinates, coverage extremes and a wrong-sign base, one per bin
      write_reg(CSR_BINSIZE, 20'd1);
      send_base(28'hFFFFFFC, 16'sd32767, 1'b1, 1'b0);
      send_base(28'hFFFFFFD, 16'sd0, 1'b1, 1'b0);
      send_base(28'hFFFFFFE, -16'sd5, 1'b1, 1'b0);
      send_base(28'hFFFFFFF, 16'sd1, 1'b1, 1'b1);
      regions++;

      // minus strand walking down to coordinate zero
      write_reg(CSR_STRAND, 20'd1);
      write_reg(CSR_BINSIZE, 20'd2);
      send_base(28'd4, -16'sd32768, 1'b1, 1'b0);
      send_base(28'd3, -16'sd1, 1'b1, 1'b0);
      send_base(28'd2, 16'sd3, 1'b1, 1'b0);
      send_base(28'd1, 16'sd0, 1'b1, 1'b0);
      send_base(28'd0, -16'sd100, 1'b1, 1'b1);
      regions++;

      // a lone unmappable base: nothing kept, no bin
      send_base(28'd1000, -16'sd7, 1'b0, 1'b1);
      regions++;

      // unmappable base far into a long walk masks its neighbors only
      write_reg(CSR_STRAND, 20'd0);
      write_reg(CSR_BINSIZE, 20'd0);
      for (int i = 0; i < 8; i++)
         send_base(POS_W'(5000 + i * 20), COV_W'(50 + i), (i != 3), (i == 7));
      regions++;

      // random regions; every region boundary lets all bins drain first
      while (items_sent < N_ITEMS) begin
         req_busy = $urandom_range(0, 2) != 0;
         r = $urandom_range(0, 99);
         if (r < 30) write_reg(CSR_STRAND, CSR_W'($urandom));
         r = $urandom_range(0, 99);
         if (r < 25) write_reg(CSR_BINSIZE, CSR_W'($urandom_range(1, 4)));
         else if (r < 40) write_reg(CSR_BINSIZE, CSR_W'($urandom_range(5, 20)));
         else if (r < 45) write_reg(CSR_BINSIZE, 20'hFFFFF);
         else if (r < 48) write_reg(CSR_BINSIZE, 20'd0);
         else if (r < 52) write_reg(CSR_BINSIZE, CSR_W'($urandom));
         else wait_idle();
         if (bsize_now <= 1 && $urandom_range(0, 99) < 30) len = $urandom_range(65, 90);
         else len = $urandom_range(1, 40);
         r = $urandom_range(0, 99);
         if (r < 70) send_region(len, 0, 0);
         else if (r < 88) send_region(len, 15, 0);
         else send_region(len, 100, 1);
      end

      wait_idle();
      $display("covered %0d items in %0d regions, %0d bins received",
               items_sent, regions, bins_seen);
      $display("both strands, bin sizes from zero to full width, masked and merged bins");
      if (fail_count == 0 && pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
